// File: hdl/atte_pkg.sv
// ----------------------------------------------------------------------------
// ANSI text terminal engine package
// Shared types, character codes and helper functions for the terminal engine.
// ----------------------------------------------------------------------------
package atte_pkg;

  localparam int ARG_W = 14;

  // Item operations
  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_READ = 1'b1;

  // Control bytes and sequence ranges
  localparam logic [7:0] CH_BS       = 8'd8;
  localparam logic [7:0] CH_TAB      = 8'd9;
  localparam logic [7:0] CH_LF       = 8'd10;
  localparam logic [7:0] CH_CR       = 8'd13;
  localparam logic [7:0] CH_ESC      = 8'd27;
  localparam logic [7:0] CH_CSI      = 8'd155;
  localparam logic [7:0] CH_LBRACKET = 8'h5B;
  localparam logic [7:0] CH_SEMI     = 8'h3B;
  localparam logic [7:0] CH_0        = 8'h30;
  localparam logic [7:0] CH_9        = 8'h39;
  localparam logic [7:0] FINAL_LO    = 8'd64;
  localparam logic [7:0] FINAL_HI    = 8'd126;
  localparam logic [7:0] SIMPLE_HI   = 8'd94;
  localparam logic [7:0] BLANK_CHAR  = 8'h20;

  // Final bytes of control sequences
  localparam logic [7:0] FIN_UP      = 8'h41;
  localparam logic [7:0] FIN_DOWN    = 8'h42;
  localparam logic [7:0] FIN_RIGHT   = 8'h43;
  localparam logic [7:0] FIN_LEFT    = 8'h44;
  localparam logic [7:0] FIN_HOME    = 8'h48;
  localparam logic [7:0] FIN_CLR_SCR = 8'h4A;
  localparam logic [7:0] FIN_CLR_LN  = 8'h4B;
  localparam logic [7:0] FIN_SC_SUB  = 8'h53;
  localparam logic [7:0] FIN_SC_ADD  = 8'h54;
  localparam logic [7:0] FIN_SGR     = 8'h6D;

  // SGR codes
  localparam logic [ARG_W-1:0] SGR_RESET  = 14'd0;
  localparam logic [ARG_W-1:0] SGR_BOLD   = 14'd1;
  localparam logic [ARG_W-1:0] SGR_HIDE   = 14'd9;
  localparam logic [ARG_W-1:0] SGR_NORMAL = 14'd22;
  localparam logic [ARG_W-1:0] SGR_REVEAL = 14'd28;
  localparam logic [ARG_W-1:0] SGR_FG_LO  = 14'd30;
  localparam logic [ARG_W-1:0] SGR_FG_HI  = 14'd37;
  localparam logic [ARG_W-1:0] SGR_FG_DEF = 14'd39;
  localparam logic [ARG_W-1:0] SGR_BG_LO  = 14'd40;
  localparam logic [ARG_W-1:0] SGR_BG_HI  = 14'd47;

  // Erase-in-line modes
  localparam logic [ARG_W-1:0] ERASE_TO_END    = 14'd0;
  localparam logic [ARG_W-1:0] ERASE_TO_CURSOR = 14'd1;
  localparam logic [ARG_W-1:0] ERASE_ALL       = 14'd2;

  localparam logic [ARG_W-1:0] PARAM_MAX = 14'd9999;
  localparam logic [3:0]       RESET_FG  = 4'd7;

  localparam logic signed [15:0] SCROLL_MIN = -16'sd1024;
  localparam logic signed [15:0] SCROLL_MAX = 16'sd1023;

  typedef enum logic [3:0] {
    K_READ, K_PRINT, K_BS, K_CR, K_LF, K_TAB, K_NOP, K_UP, K_DOWN, K_RIGHT,
    K_LEFT, K_HOME, K_CLR_SCREEN, K_CLR_LINE, K_SCROLL_SUB, K_SCROLL_ADD
  } kind_t;

  typedef enum logic [1:0] {PH_TEXT, PH_ESC, PH_CSI} phase_t;

  typedef enum logic [1:0] {FR_IDLE, FR_SGR, FR_PUSH} front_state_t;

  typedef enum logic [2:0] {
    BK_CLEAR, BK_IDLE, BK_EXEC, BK_BLANK, BK_SWEEP, BK_DONE
  } back_state_t;

  typedef struct packed {
    kind_t            kind;
    logic [7:0]       ch;
    logic [11:0]      idx;
    logic [ARG_W-1:0] arg0;
    logic [ARG_W-1:0] arg1;
    logic [3:0]       fg;
    logic [3:0]       bg;
    logic             bell;
  } entry_t;

  typedef struct packed {
    logic clearing;
  } back_status_t;

  // Black stays black in the bright palette.
  function automatic logic [3:0] palette(input logic [2:0] sel, input logic hi);
    logic [3:0] c;
    begin
      case (sel)
        3'd0: c = 4'd0;
        3'd1: c = 4'd4;
        3'd2: c = 4'd2;
        3'd3: c = 4'd6;
        3'd4: c = 4'd1;
        3'd5: c = 4'd5;
        3'd6: c = 4'd3;
        default: c = 4'd7;
      endcase
      palette = (hi && (c != 4'd0)) ? (c | 4'd8) : c;
    end
  endfunction

endpackage

// File: hdl/atte_queue.sv
// ----------------------------------------------------------------------------
// Command queue
// Two-entry queue between the byte parser and the command executor.
// ----------------------------------------------------------------------------
module atte_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  atte_pkg::entry_t  push_entry,
  output logic              full,
  input  logic              pop,
  output atte_pkg::entry_t  head,
  output logic              empty
);

  atte_pkg::entry_t slots [2];
  logic       wp;
  logic       rp;
  logic [1:0] count;

  assign full  = (count == 2'd2);
  assign empty = (count == 2'd0);
  assign head  = slots[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= 1'b0;
      rp    <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) begin
        wp <= ~wp;
      end
      if (pop) begin
        rp <= ~rp;
      end
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wp] <= push_entry;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("Queue written while full.");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) pop |-> !empty)
    else $error("Queue read while empty.");
  a_count_range: assert property (@(posedge clk) disable iff (rst) count <= 2'd2)
    else $error("Queue count out of range.");

endmodule

// File: hdl/atte_front.sv
// ----------------------------------------------------------------------------
// Byte parser
// Accepts items, runs the escape parser and the color state, and queues one
// command for each item.
// ----------------------------------------------------------------------------
module atte_front #(
  parameter int ESC_DEPTH = 15
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [3:0]             cfg_data,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic                   op,
  input  logic [7:0]             char_byte,
  input  logic [11:0]            cell_index,
  input  atte_pkg::back_status_t back_status,
  output logic                   q_push,
  output atte_pkg::entry_t       q_entry,
  input  logic                   q_full
);

  localparam int VW = $clog2(ESC_DEPTH + 1);
  localparam int AW = atte_pkg::ARG_W;

  atte_pkg::front_state_t state, state_next;
  atte_pkg::phase_t       phase, phase_next;
  logic [VW-1:0] cnt, cnt_next;
  logic [VW-1:0] n_sc, n_sc_next;
  logic [VW-1:0] sgr_i, sgr_i_next;
  logic [AW-1:0] acc, acc_next;
  logic          foreign, foreign_next;
  logic [AW-1:0] vals [ESC_DEPTH + 1];
  logic [3:0]    fg, fg_next;
  logic [3:0]    bg, bg_next;
  logic [3:0]    hidden_fg, hidden_fg_next;
  logic          bright, bright_next;
  logic [3:0]    def_fg, def_fg_next;

  logic          accept;
  logic          val_we;
  logic [VW-1:0] val_wi;
  logic [AW-1:0] code;
  logic [AW-1:0] v0;
  logic [AW-1:0] v1;
  logic [AW-1:0] v0_or1;
  logic [AW-1:0] v1_or1;
  logic [16:0]   acc_mul;

  assign in_stall = (state != atte_pkg::FR_IDLE) || q_full || back_status.clearing;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    state_next     = state;
    phase_next     = phase;
    cnt_next       = cnt;
    n_sc_next      = n_sc;
    sgr_i_next     = sgr_i;
    acc_next       = acc;
    foreign_next   = foreign;
    fg_next        = fg;
    bg_next        = bg;
    hidden_fg_next = hidden_fg;
    bright_next    = bright;
    def_fg_next    = cfg_we ? cfg_data : def_fg;
    val_we         = 1'b0;
    val_wi         = n_sc;
    q_push         = 1'b0;

    code    = vals[sgr_i];
    v0      = (n_sc == '0) ? acc : vals[0];
    v1      = (n_sc == VW'(1)) ? acc : vals[1];
    v0_or1  = (v0 != '0) ? v0 : AW'(1);
    v1_or1  = ((n_sc != '0) && (v1 != '0)) ? v1 : AW'(1);
    acc_mul = 17'(acc) * 17'd10 + 17'(8'(char_byte - atte_pkg::CH_0));

    q_entry      = '0;
    q_entry.kind = atte_pkg::K_NOP;
    q_entry.ch   = char_byte;
    q_entry.idx  = cell_index;
    q_entry.fg   = fg;
    q_entry.bg   = bg;

    case (state)
      atte_pkg::FR_IDLE: begin
        if (accept) begin
          q_push = 1'b1;
          if (op == atte_pkg::OP_READ) begin
            q_entry.kind = atte_pkg::K_READ;
          end else begin
            case (phase)
              atte_pkg::PH_ESC: begin
                cnt_next     = '0;
                n_sc_next    = '0;
                acc_next     = '0;
                foreign_next = 1'b0;
                if (char_byte == atte_pkg::CH_LBRACKET) begin
                  phase_next = atte_pkg::PH_CSI;
                end else begin
                  phase_next   = atte_pkg::PH_TEXT;
                  q_entry.bell = !(char_byte inside {[atte_pkg::FINAL_LO:atte_pkg::SIMPLE_HI]});
                end
              end
              atte_pkg::PH_CSI: begin
                if (cnt >= VW'(ESC_DEPTH)) begin
                  phase_next   = atte_pkg::PH_TEXT;
                  cnt_next     = '0;
                  q_entry.bell = 1'b1;
                end else if (char_byte inside {[atte_pkg::FINAL_LO:atte_pkg::FINAL_HI]}) begin
                  phase_next = atte_pkg::PH_TEXT;
                  cnt_next   = '0;
                  if (!foreign) begin
                    q_entry.arg0 = v0_or1;
                    case (char_byte)
                      atte_pkg::FIN_UP:      q_entry.kind = atte_pkg::K_UP;
                      atte_pkg::FIN_DOWN:    q_entry.kind = atte_pkg::K_DOWN;
                      atte_pkg::FIN_RIGHT:   q_entry.kind = atte_pkg::K_RIGHT;
                      atte_pkg::FIN_LEFT:    q_entry.kind = atte_pkg::K_LEFT;
                      atte_pkg::FIN_SC_SUB:  q_entry.kind = atte_pkg::K_SCROLL_SUB;
                      atte_pkg::FIN_SC_ADD:  q_entry.kind = atte_pkg::K_SCROLL_ADD;
                      atte_pkg::FIN_CLR_SCR: q_entry.kind = atte_pkg::K_CLR_SCREEN;
                      atte_pkg::FIN_HOME: begin
                        q_entry.kind = atte_pkg::K_HOME;
                        q_entry.arg1 = v1_or1;
                      end
                      atte_pkg::FIN_CLR_LN: begin
                        q_entry.kind = atte_pkg::K_CLR_LINE;
                        q_entry.arg0 = v0;
                      end
                      atte_pkg::FIN_SGR: begin
                        // The last number is still in the accumulator; park it
                        // with the others and walk the list one code a cycle.
                        q_push     = 1'b0;
                        val_we     = 1'b1;
                        sgr_i_next = '0;
                        state_next = atte_pkg::FR_SGR;
                      end
                      default: q_entry.kind = atte_pkg::K_NOP;
                    endcase
                  end
                end else begin
                  cnt_next = cnt + VW'(1);
                  if (char_byte == atte_pkg::CH_SEMI) begin
                    val_we    = 1'b1;
                    n_sc_next = n_sc + VW'(1);
                    acc_next  = '0;
                  end else if (char_byte inside {[atte_pkg::CH_0:atte_pkg::CH_9]}) begin
                    acc_next = (acc_mul > 17'(atte_pkg::PARAM_MAX)) ? atte_pkg::PARAM_MAX
                                                                     : AW'(acc_mul);
                  end else begin
                    foreign_next = 1'b1;
                  end
                end
              end
              default: begin
                case (char_byte)
                  atte_pkg::CH_ESC: begin
                    phase_next = atte_pkg::PH_ESC;
                    cnt_next   = '0;
                  end
                  atte_pkg::CH_CSI: begin
                    phase_next   = atte_pkg::PH_CSI;
                    cnt_next     = '0;
                    n_sc_next    = '0;
                    acc_next     = '0;
                    foreign_next = 1'b0;
                  end
                  atte_pkg::CH_BS:  q_entry.kind = atte_pkg::K_BS;
                  atte_pkg::CH_CR:  q_entry.kind = atte_pkg::K_CR;
                  atte_pkg::CH_LF:  q_entry.kind = atte_pkg::K_LF;
                  atte_pkg::CH_TAB: q_entry.kind = atte_pkg::K_TAB;
                  default:          q_entry.kind = atte_pkg::K_PRINT;
                endcase
              end
            endcase
          end
        end
      end
      atte_pkg::FR_SGR: begin
        if ((code == atte_pkg::SGR_RESET) || (code == atte_pkg::SGR_NORMAL)) begin
          fg_next     = def_fg;
          bg_next     = 4'd0;
          bright_next = 1'b0;
        end else if (code == atte_pkg::SGR_BOLD) begin
          bright_next = 1'b1;
        end else if (code == atte_pkg::SGR_HIDE) begin
          hidden_fg_next = fg;
          fg_next        = bg;
        end else if (code == atte_pkg::SGR_REVEAL) begin
          fg_next = hidden_fg;
        end else if (code inside {[atte_pkg::SGR_FG_LO:atte_pkg::SGR_FG_HI]}) begin
          fg_next = atte_pkg::palette(3'(code - atte_pkg::SGR_FG_LO), bright);
        end else if (code == atte_pkg::SGR_FG_DEF) begin
          fg_next = def_fg;
        end else if (code inside {[atte_pkg::SGR_BG_LO:atte_pkg::SGR_BG_HI]}) begin
          bg_next = atte_pkg::palette(3'(code - atte_pkg::SGR_BG_LO), bright);
        end
        if (sgr_i == n_sc) begin
          state_next = atte_pkg::FR_PUSH;
        end else begin
          sgr_i_next = sgr_i + VW'(1);
        end
      end
      atte_pkg::FR_PUSH: begin
        if (!q_full) begin
          q_push     = 1'b1;
          state_next = atte_pkg::FR_IDLE;
        end
      end
      default: state_next = atte_pkg::FR_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= atte_pkg::FR_IDLE;
      phase     <= atte_pkg::PH_TEXT;
      cnt       <= '0;
      n_sc      <= '0;
      sgr_i     <= '0;
      acc       <= '0;
      foreign   <= 1'b0;
      fg        <= atte_pkg::RESET_FG;
      bg        <= 4'd0;
      hidden_fg <= 4'd0;
      bright    <= 1'b0;
      def_fg    <= atte_pkg::RESET_FG;
    end else begin
      state     <= state_next;
      phase     <= phase_next;
      cnt       <= cnt_next;
      n_sc      <= n_sc_next;
      sgr_i     <= sgr_i_next;
      acc       <= acc_next;
      foreign   <= foreign_next;
      fg        <= fg_next;
      bg        <= bg_next;
      hidden_fg <= hidden_fg_next;
      bright    <= bright_next;
      def_fg    <= def_fg_next;
    end
  end

  always_ff @(posedge clk) begin
    if (val_we) begin
      vals[val_wi] <= acc;
    end
  end

endmodule

// File: hdl/atte_back.sv
// ----------------------------------------------------------------------------
// Command executor
// Owns the cell store, cursor, line ends and scroll position, carries out
// queued commands and holds the result register.
// ----------------------------------------------------------------------------
module atte_back #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 32
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   q_empty,
  input  atte_pkg::entry_t       q_head,
  output logic                   q_pop,
  output atte_pkg::back_status_t back_status,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [15:0]            cell_value,
  output logic [6:0]             cursor_col,
  output logic [4:0]             cursor_row,
  output logic signed [10:0]     view_scroll,
  output logic                   bell
);

  localparam int CELLS = COLUMNS * ROWS;
  localparam int AW    = $clog2(CELLS);
  localparam int EW    = $clog2(CELLS + 1);
  localparam int CW    = $clog2(COLUMNS);
  localparam int RW    = $clog2(ROWS);

  atte_pkg::back_state_t state, state_next;
  atte_pkg::entry_t      ent, ent_next;
  logic [CW-1:0]         col, col_next;
  logic [RW-1:0]         row, row_next;
  logic signed [10:0]    scroll, scroll_next;
  logic [1:0]            tab_i, tab_i_next;
  logic [EW-1:0]         sw_addr, sw_addr_next;
  logic [EW-1:0]         sw_end, sw_end_next;
  logic [15:0]           sw_data, sw_data_next;
  logic                  rd_ok, rd_ok_next;
  logic [15:0]           rd_data;
  logic [7:0]            line_end [ROWS];

  logic [15:0]           mem [CELLS];
  logic                  mem_we;
  logic [AW-1:0]         mem_wa;
  logic [15:0]           mem_wd;
  logic                  mem_re;
  logic [AW-1:0]         mem_ra;

  logic                  le_we;
  logic                  le_clear;
  logic                  out_load;

  logic [EW-1:0]         base;
  logic [EW-1:0]         cur_addr;
  logic [15:0]           blank;
  logic [RW-1:0]         row_prev;
  logic [7:0]            le_prev;
  logic [16:0]           mv;
  logic signed [15:0]    s_wide;

  assign back_status.clearing = (state == atte_pkg::BK_CLEAR);

  assign base     = EW'(EW'(row) * EW'(COLUMNS));
  assign cur_addr = base + EW'(col);
  assign blank    = {ent.bg, ent.fg, atte_pkg::BLANK_CHAR};
  assign row_prev = (row == '0) ? RW'(ROWS - 1) : row - RW'(1);
  assign le_prev  = line_end[row_prev];

  always_comb begin
    state_next   = state;
    ent_next     = ent;
    col_next     = col;
    row_next     = row;
    scroll_next  = scroll;
    tab_i_next   = tab_i;
    sw_addr_next = sw_addr;
    sw_end_next  = sw_end;
    sw_data_next = sw_data;
    rd_ok_next   = rd_ok;
    q_pop        = 1'b0;
    mem_we       = 1'b0;
    mem_wa       = cur_addr[AW-1:0];
    mem_wd       = blank;
    mem_re       = 1'b0;
    mem_ra       = AW'(ent.idx);
    le_we        = 1'b0;
    le_clear     = 1'b0;
    out_load     = 1'b0;
    mv           = '0;
    s_wide       = 16'(scroll);

    case (state)
      atte_pkg::BK_CLEAR: begin
        mem_we       = 1'b1;
        mem_wa       = sw_addr[AW-1:0];
        mem_wd       = sw_data;
        sw_addr_next = sw_addr + EW'(1);
        if (sw_addr + EW'(1) == sw_end) begin
          state_next = atte_pkg::BK_IDLE;
        end
      end
      atte_pkg::BK_IDLE: begin
        if (!q_empty) begin
          q_pop      = 1'b1;
          ent_next   = q_head;
          tab_i_next = 2'd0;
          state_next = atte_pkg::BK_EXEC;
        end
      end
      atte_pkg::BK_EXEC: begin
        state_next = atte_pkg::BK_DONE;
        rd_ok_next = 1'b0;
        case (ent.kind)
          atte_pkg::K_READ: begin
            if (32'(ent.idx) < CELLS) begin
              mem_re     = 1'b1;
              rd_ok_next = 1'b1;
            end
          end
          atte_pkg::K_PRINT, atte_pkg::K_TAB: begin
            mem_we = 1'b1;
            mem_wd = (ent.kind == atte_pkg::K_TAB) ? blank : {ent.bg, ent.fg, ent.ch};
            if (32'(col) == COLUMNS - 1) begin
              col_next = '0;
              row_next = (32'(row) == ROWS - 1) ? '0 : row + RW'(1);
            end else begin
              col_next = col + CW'(1);
            end
            if (ent.kind == atte_pkg::K_TAB) begin
              tab_i_next = tab_i + 2'd1;
              if (tab_i != 2'd3) begin
                state_next = atte_pkg::BK_EXEC;
              end
            end
          end
          atte_pkg::K_BS: begin
            if (col != '0) begin
              col_next = col - CW'(1);
            end else begin
              row_next = row_prev;
              col_next = (32'(le_prev) >= COLUMNS) ? CW'(COLUMNS - 1) : CW'(le_prev);
            end
            state_next = atte_pkg::BK_BLANK;
          end
          atte_pkg::K_CR: begin
            sw_addr_next = base;
            sw_end_next  = cur_addr;
            sw_data_next = blank;
            col_next     = '0;
            if (col != '0) begin
              state_next = atte_pkg::BK_SWEEP;
            end
          end
          atte_pkg::K_LF: begin
            le_we    = 1'b1;
            col_next = '0;
            row_next = (32'(row) == ROWS - 1) ? '0 : row + RW'(1);
          end
          atte_pkg::K_UP: begin
            mv       = 17'(row) - 17'(ent.arg0);
            row_next = (17'(ent.arg0) > 17'(row)) ? '0 : RW'(mv);
          end
          atte_pkg::K_DOWN: begin
            mv       = 17'(row) + 17'(ent.arg0);
            row_next = (mv > 17'(ROWS - 1)) ? RW'(ROWS - 1) : RW'(mv);
          end
          atte_pkg::K_LEFT: begin
            mv       = 17'(col) - 17'(ent.arg0);
            col_next = (17'(ent.arg0) > 17'(col)) ? '0 : CW'(mv);
          end
          atte_pkg::K_RIGHT: begin
            mv       = 17'(col) + 17'(ent.arg0);
            col_next = (mv > 17'(COLUMNS - 1)) ? CW'(COLUMNS - 1) : CW'(mv);
          end
          atte_pkg::K_HOME: begin
            mv       = 17'(ent.arg0) - 17'd1;
            row_next = (mv > 17'(ROWS - 1)) ? RW'(ROWS - 1) : RW'(mv);
            mv       = 17'(ent.arg1) - 17'd1;
            col_next = (mv > 17'(COLUMNS - 1)) ? CW'(COLUMNS - 1) : CW'(mv);
          end
          atte_pkg::K_CLR_SCREEN: begin
            sw_addr_next = '0;
            sw_end_next  = EW'(CELLS);
            sw_data_next = blank;
            le_clear     = 1'b1;
            scroll_next  = '0;
            col_next     = '0;
            row_next     = '0;
            state_next   = atte_pkg::BK_SWEEP;
          end
          atte_pkg::K_CLR_LINE: begin
            sw_data_next = blank;
            if (ent.arg0 == atte_pkg::ERASE_TO_END) begin
              sw_addr_next = cur_addr;
              sw_end_next  = base + EW'(COLUMNS);
              state_next   = atte_pkg::BK_SWEEP;
            end else if (ent.arg0 == atte_pkg::ERASE_TO_CURSOR) begin
              sw_addr_next = base;
              sw_end_next  = cur_addr + EW'(1);
              state_next   = atte_pkg::BK_SWEEP;
            end else if (ent.arg0 == atte_pkg::ERASE_ALL) begin
              sw_addr_next = base;
              sw_end_next  = base + EW'(COLUMNS);
              state_next   = atte_pkg::BK_SWEEP;
            end
          end
          atte_pkg::K_SCROLL_SUB, atte_pkg::K_SCROLL_ADD: begin
            if (ent.kind == atte_pkg::K_SCROLL_SUB) begin
              s_wide = 16'(scroll) - $signed({2'b00, ent.arg0});
            end else begin
              s_wide = 16'(scroll) + $signed({2'b00, ent.arg0});
            end
            if (s_wide < atte_pkg::SCROLL_MIN) begin
              scroll_next = 11'(atte_pkg::SCROLL_MIN);
            end else if (s_wide > atte_pkg::SCROLL_MAX) begin
              scroll_next = 11'(atte_pkg::SCROLL_MAX);
            end else begin
              scroll_next = 11'(s_wide);
            end
          end
          default: state_next = atte_pkg::BK_DONE;
        endcase
      end
      atte_pkg::BK_BLANK: begin
        mem_we     = 1'b1;
        state_next = atte_pkg::BK_DONE;
      end
      atte_pkg::BK_SWEEP: begin
        mem_we       = 1'b1;
        mem_wa       = sw_addr[AW-1:0];
        mem_wd       = sw_data;
        sw_addr_next = sw_addr + EW'(1);
        if (sw_addr + EW'(1) == sw_end) begin
          state_next = atte_pkg::BK_DONE;
        end
      end
      atte_pkg::BK_DONE: begin
        if (!out_valid || !out_stall) begin
          out_load   = 1'b1;
          state_next = atte_pkg::BK_IDLE;
        end
      end
      default: state_next = atte_pkg::BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= atte_pkg::BK_CLEAR;
      col     <= '0;
      row     <= '0;
      scroll  <= '0;
      tab_i   <= 2'd0;
      sw_addr <= '0;
      sw_end  <= EW'(CELLS);
      sw_data <= {4'd0, atte_pkg::RESET_FG, atte_pkg::BLANK_CHAR};
      rd_ok   <= 1'b0;
    end else begin
      state   <= state_next;
      col     <= col_next;
      row     <= row_next;
      scroll  <= scroll_next;
      tab_i   <= tab_i_next;
      sw_addr <= sw_addr_next;
      sw_end  <= sw_end_next;
      sw_data <= sw_data_next;
      rd_ok   <= rd_ok_next;
    end
  end

  always_ff @(posedge clk) begin
    ent <= ent_next;
  end

  always_ff @(posedge clk) begin
    if (rst || le_clear) begin
      for (int i = 0; i < ROWS; i++) begin
        line_end[i] <= 8'hFF;
      end
    end else if (le_we) begin
      line_end[row] <= 8'(col);
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      rd_data <= mem[mem_ra];
    end
  end

  // Result register: the executor only finishes a command when it is free.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      cell_value  <= rd_ok ? rd_data : 16'd0;
      cursor_col  <= 7'(col);
      cursor_row  <= 5'(row);
      view_scroll <= scroll;
      bell        <= ent.bell;
    end
  end

  a_clear_no_pop: assert property (@(posedge clk) disable iff (rst)
      (state == atte_pkg::BK_CLEAR) |-> !q_pop)
    else $error("Command taken during the clearing pass.");
  a_sweep_bound: assert property (@(posedge clk) disable iff (rst)
      (state == atte_pkg::BK_SWEEP) |-> (sw_addr < sw_end))
    else $error("Sweep address ran past its end.");
  a_cursor_range: assert property (@(posedge clk) disable iff (rst)
      (32'(col) < COLUMNS) && (32'(row) < ROWS))
    else $error("Cursor left the screen.");

endmodule

// File: hdl/ansi_text_terminal_engine.sv
// ----------------------------------------------------------------------------
// ANSI text terminal engine
// Text terminal with a cell store, cursor, colors and an escape parser.
// ----------------------------------------------------------------------------
// Usage: each input transaction either writes one byte to the terminal
// (op 0, char_byte) or reads one cell of the store (op 1, cell_index). Every
// input transaction yields exactly one output transaction carrying the cell
// value (zero for byte writes and out-of-range reads), the cursor position,
// the scroll position and a bell flag for dropped escape sequences.
// A plain byte or a cursor command passes through the executor's idle,
// execute and done states. A tab repeats the execute state for each blank
// it writes, an SGR list is walked one code at a time in the parser, and CR
// and line erase blank their cells one by one in the sweep state. Clear
// screen walks the whole store through the single store write port. A
// two-entry queue lets the parser take bytes while the executor works.
// After reset the store is blanked in a pass over all ROWS*COLUMNS cells
// (2560 at the default size), during which in_stall is high; cfg writes are
// taken at any time. When out_stall is high the result is held and the
// executor waits on it, and the input side stalls once the queue fills.
// ----------------------------------------------------------------------------
module ansi_text_terminal_engine #(
  parameter int COLUMNS   = 80,
  parameter int ROWS      = 32,
  parameter int ESC_DEPTH = 15
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [3:0]         cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               op,
  input  logic [7:0]         char_byte,
  input  logic [11:0]        cell_index,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [15:0]        cell_value,
  output logic [6:0]         cursor_col,
  output logic [4:0]         cursor_row,
  output logic signed [10:0] view_scroll,
  output logic               bell
);

  atte_pkg::entry_t       q_entry;
  atte_pkg::entry_t       q_head;
  atte_pkg::back_status_t back_status;
  logic                   q_push;
  logic                   q_pop;
  logic                   q_full;
  logic                   q_empty;

  atte_front #(
    .ESC_DEPTH(ESC_DEPTH)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .op         (op),
    .char_byte  (char_byte),
    .cell_index (cell_index),
    .back_status(back_status),
    .q_push     (q_push),
    .q_entry    (q_entry),
    .q_full     (q_full)
  );

  atte_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_entry(q_entry),
    .full      (q_full),
    .pop       (q_pop),
    .head      (q_head),
    .empty     (q_empty)
  );

  atte_back #(
    .COLUMNS(COLUMNS),
    .ROWS   (ROWS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .q_empty    (q_empty),
    .q_head     (q_head),
    .q_pop      (q_pop),
    .back_status(back_status),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .cell_value (cell_value),
    .cursor_col (cursor_col),
    .cursor_row (cursor_row),
    .view_scroll(view_scroll),
    .bell       (bell)
  );

endmodule

// File: tb/sv/atte_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Terminal engine checker
// Watches the input, output and register ports of the terminal engine. It
// keeps its own copy of the screen, cursor, colors and escape parser state,
// predicts the result of every accepted input transaction and compares each
// accepted output transaction, field by field, with the oldest prediction.
// ----------------------------------------------------------------------------
module atte_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [3:0]         cfg_data,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic               op,
  input  logic [7:0]         char_byte,
  input  logic [11:0]        cell_index,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic [15:0]        cell_value,
  input  logic [6:0]         cursor_col,
  input  logic [4:0]         cursor_row,
  input  logic signed [10:0] view_scroll,
  input  logic               bell,
  output int                 fail_count,
  output int                 pending
);

  localparam int NCOLS  = 80;
  localparam int NROWS  = 32;
  localparam int NCELLS = NCOLS * NROWS;
  localparam int DEPTH  = 15;

  typedef struct packed {
    logic [15:0] value;
    logic [6:0]  col;
    logic [4:0]  row;
    logic [10:0] scroll;
    logic        bell;
  } term_result_t;

  logic [15:0]       screen [NCELLS];
  logic [7:0]        line_end [NROWS];
  logic [7:0]        seq_buf [DEPTH];
  int                seq_len;
  atte_pkg::phase_t  parse_phase;
  int                col_q, row_q, scroll_q;
  logic [3:0]        fg_q, bg_q, saved_fg, default_fg;
  logic              bright_q;

  term_result_t expected_results[$];

  logic [3:0] normal_colors [8] = '{4'd0, 4'd4, 4'd2, 4'd6, 4'd1, 4'd5, 4'd3, 4'd7};

  assign pending = expected_results.size();

  function automatic logic [15:0] blank_glyph();
    return {bg_q, fg_q, atte_pkg::BLANK_CHAR};
  endfunction

  function automatic int clamp_to(int v, int lim);
    if (v < 0) return 0;
    if (v > lim - 1) return lim - 1;
    return v;
  endfunction

  function automatic void put_glyph(logic [7:0] c);
    screen[row_q * NCOLS + col_q] = {bg_q, fg_q, c};
    col_q++;
    if (col_q >= NCOLS) begin
      col_q = 0;
      row_q++;
      if (row_q >= NROWS) row_q = 0;
    end
  endfunction

  function automatic void apply_color(int code);
    logic [3:0] pick;
    pick = 4'd0;
    if (code >= 30 && code <= 37) pick = normal_colors[code - 30];
    if (code >= 40 && code <= 47) pick = normal_colors[code - 40];
    // Black has no bright variant.
    if (bright_q && pick != 4'd0) pick = pick | 4'd8;
    if (code == 0 || code == 22) begin
      fg_q = default_fg;
      bg_q = 4'd0;
      bright_q = 1'b0;
    end else if (code == 1) begin
      bright_q = 1'b1;
    end else if (code == 9) begin
      saved_fg = fg_q;
      fg_q = bg_q;
    end else if (code == 28) begin
      fg_q = saved_fg;
    end else if (code >= 30 && code <= 37) begin
      fg_q = pick;
    end else if (code == 39) begin
      fg_q = default_fg;
    end else if (code >= 40 && code <= 47) begin
      bg_q = pick;
    end
  endfunction

  function automatic void run_sequence(logic [7:0] fin);
    int vals [DEPTH + 1];
    int n, acc, v, a, b, s;
    logic foreign;
    n = 0;
    acc = 0;
    foreign = 1'b0;
    if (seq_len > 0) begin
      for (int i = 0; i < seq_len; i++) begin
        if (seq_buf[i] == atte_pkg::CH_SEMI) begin
          vals[n] = acc;
          n++;
          acc = 0;
        end else if (seq_buf[i] >= atte_pkg::CH_0 && seq_buf[i] <= atte_pkg::CH_9) begin
          acc = acc * 10 + int'(seq_buf[i] - atte_pkg::CH_0);
          if (acc > 9999) acc = 9999;
        end else begin
          foreign = 1'b1;
        end
      end
      vals[n] = acc;
      n++;
    end
    if (foreign) return;
    // Absent or zero counts mean one for moves and scrolls.
    v = (n > 0 && vals[0] != 0) ? vals[0] : 1;
    case (fin)
      atte_pkg::FIN_UP:    row_q = clamp_to(row_q - v, NROWS);
      atte_pkg::FIN_DOWN:  row_q = clamp_to(row_q + v, NROWS);
      atte_pkg::FIN_RIGHT: col_q = clamp_to(col_q + v, NCOLS);
      atte_pkg::FIN_LEFT:  col_q = clamp_to(col_q - v, NCOLS);
      atte_pkg::FIN_HOME: begin
        row_q = clamp_to(v - 1, NROWS);
        col_q = clamp_to(((n > 1 && vals[1] != 0) ? vals[1] : 1) - 1, NCOLS);
      end
      atte_pkg::FIN_CLR_SCR: begin
        for (int i = 0; i < NCELLS; i++) screen[i] = blank_glyph();
        for (int i = 0; i < NROWS; i++) line_end[i] = 8'd255;
        scroll_q = 0;
        col_q = 0;
        row_q = 0;
      end
      atte_pkg::FIN_CLR_LN: begin
        s = (n > 0) ? vals[0] : 0;
        a = 0;
        b = 0;
        if (s == 0) begin
          a = col_q;
          b = NCOLS;
        end else if (s == 1) begin
          b = col_q + 1;
        end else if (s == 2) begin
          b = NCOLS;
        end
        for (int i = a; i < b && i < NCOLS; i++) screen[row_q * NCOLS + i] = blank_glyph();
      end
      atte_pkg::FIN_SC_SUB, atte_pkg::FIN_SC_ADD: begin
        s = (fin == atte_pkg::FIN_SC_SUB) ? scroll_q - v : scroll_q + v;
        if (s < -1024) s = -1024;
        if (s > 1023) s = 1023;
        scroll_q = s;
      end
      atte_pkg::FIN_SGR: begin
        if (n == 0) apply_color(0);
        for (int i = 0; i < n; i++) apply_color(vals[i]);
      end
      default: ;
    endcase
  endfunction

  // Returns the bell flag for this byte.
  function automatic logic terminal_take_byte(logic [7:0] c);
    if (parse_phase == atte_pkg::PH_ESC) begin
      seq_len = 0;
      if (c == atte_pkg::CH_LBRACKET) begin
        parse_phase = atte_pkg::PH_CSI;
        return 1'b0;
      end
      parse_phase = atte_pkg::PH_TEXT;
      return !(c >= atte_pkg::FINAL_LO && c <= atte_pkg::SIMPLE_HI);
    end
    if (parse_phase == atte_pkg::PH_CSI) begin
      if (seq_len >= DEPTH) begin
        parse_phase = atte_pkg::PH_TEXT;
        seq_len = 0;
        return 1'b1;
      end
      if (c >= atte_pkg::FINAL_LO && c <= atte_pkg::FINAL_HI) begin
        run_sequence(c);
        parse_phase = atte_pkg::PH_TEXT;
        seq_len = 0;
        return 1'b0;
      end
      seq_buf[seq_len] = c;
      seq_len++;
      return 1'b0;
    end
    if (c == atte_pkg::CH_ESC || c == atte_pkg::CH_CSI) begin
      parse_phase = (c == atte_pkg::CH_ESC) ? atte_pkg::PH_ESC : atte_pkg::PH_CSI;
      seq_len = 0;
    end else if (c == atte_pkg::CH_BS) begin
      if (col_q > 0) begin
        col_q--;
      end else begin
        row_q = (row_q == 0) ? NROWS - 1 : row_q - 1;
        col_q = int'(line_end[row_q]);
        if (col_q >= NCOLS) col_q = NCOLS - 1;
      end
      screen[row_q * NCOLS + col_q] = blank_glyph();
    end else if (c == atte_pkg::CH_CR) begin
      for (int i = 0; i < col_q; i++) screen[row_q * NCOLS + i] = blank_glyph();
      col_q = 0;
    end else if (c == atte_pkg::CH_LF) begin
      line_end[row_q] = col_q[7:0];
      col_q = 0;
      row_q++;
      if (row_q >= NROWS) row_q = 0;
    end else if (c == atte_pkg::CH_TAB) begin
      for (int i = 0; i < 4; i++) put_glyph(atte_pkg::BLANK_CHAR);
    end else begin
      put_glyph(c);
    end
    return 1'b0;
  endfunction

  always @(posedge clk) begin
    term_result_t want, got;
    logic [31:0] scroll_bits;
    if (rst) begin
      default_fg = atte_pkg::RESET_FG;
      fg_q = atte_pkg::RESET_FG;
      bg_q = 4'd0;
      saved_fg = 4'd0;
      bright_q = 1'b0;
      for (int i = 0; i < NCELLS; i++) screen[i] = blank_glyph();
      for (int i = 0; i < NROWS; i++) line_end[i] = 8'd255;
      col_q = 0;
      row_q = 0;
      scroll_q = 0;
      seq_len = 0;
      parse_phase = atte_pkg::PH_TEXT;
      expected_results.delete();
      fail_count = 0;
    end else begin
      if (cfg_we) default_fg = cfg_data;
      if (in_valid && !in_stall) begin
        want = '0;
        if (op == atte_pkg::OP_BYTE) begin
          want.bell = terminal_take_byte(char_byte);
        end else if (cell_index < NCELLS) begin
          want.value = screen[cell_index];
        end
        want.col = col_q[6:0];
        want.row = row_q[4:0];
        scroll_bits = scroll_q;
        want.scroll = scroll_bits[10:0];
        expected_results.push_back(want);
      end
      if (out_valid && !out_stall) begin
        got = '{cell_value, cursor_col, cursor_row, view_scroll, bell};
        if (expected_results.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("checker: unexpected output transaction %h", got);
        end else begin
          want = expected_results.pop_front();
          if (got != want) begin
            fail_count++;
            if (fail_count <= 10)
              $display({"checker: mismatch value %h/%h col %0d/%0d row %0d/%0d ",
                        "scroll %h/%h bell %b/%b (expected/actual)"},
                       want.value, got.value, want.col, got.col, want.row, got.row,
                       want.scroll, got.scroll, want.bell, got.bell);
          end
        end
      end
    end
  end

endmodule

// File: tb/sv/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Terminal engine testbench
// Drives directed and random byte streams and cell reads into the terminal
// engine under random sender gaps and receiver stalls, changes the default
// foreground between phases, and reports the checker's verdict.
// ----------------------------------------------------------------------------
module testbench;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_we = 1'b0;
  logic [3:0]         cfg_data = 4'd0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic               op = atte_pkg::OP_BYTE;
  logic [7:0]         char_byte = 8'd0;
  logic [11:0]        cell_index = 12'd0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [15:0]        cell_value;
  logic [6:0]         cursor_col;
  logic [4:0]         cursor_row;
  logic signed [10:0] view_scroll;
  logic               bell;
  int                 fail_count, pending;
  int                 items_sent = 0;
  int                 burst_left = 0;
  int                 idle_cycles = 0;
  int                 cycle_no = 0;
  int                 hold_left = 0;
  int                 holds_done = 0;
  int                 stall_mode = 0;

  localparam int IDLE_LIMIT = 20000;

  always #5 clk = ~clk;

  ansi_text_terminal_engine i_dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .op(op), .char_byte(char_byte),
    .cell_index(cell_index), .out_valid(out_valid), .out_stall(out_stall),
    .cell_value(cell_value), .cursor_col(cursor_col), .cursor_row(cursor_row),
    .view_scroll(view_scroll), .bell(bell)
  );

  atte_checker i_checker (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .op(op), .char_byte(char_byte),
    .cell_index(cell_index), .out_valid(out_valid), .out_stall(out_stall),
    .cell_value(cell_value), .cursor_col(cursor_col), .cursor_row(cursor_row),
    .view_scroll(view_scroll), .bell(bell), .fail_count(fail_count),
    .pending(pending)
  );

  // Receiver: two long hold-offs while the sender is busy, otherwise a stall
  // pattern that changes mode.
  always @(posedge clk) begin
    cycle_no <= cycle_no + 1;
    if (cycle_no % 97 == 0) stall_mode <= $urandom_range(0, 3);
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else if ((holds_done == 0 && items_sent >= 200) ||
                 (holds_done == 1 && items_sent >= 700)) begin
      hold_left  <= 400;
      holds_done <= holds_done + 1;
      out_stall  <= 1'b1;
    end else begin
      case (stall_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 3) == 0);
        2: out_stall <= ($urandom_range(0, 3) != 0);
        default: out_stall <= ((cycle_no % 8) < 3);
      endcase
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > IDLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  task automatic send_item(logic o, logic [7:0] b, logic [11:0] idx);
    logic taken;
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(100, 200)
                                               : $urandom_range(1, 30);
    end
    burst_left--;
    in_valid <= 1'b1;
    op <= o;
    char_byte <= b;
    cell_index <= idx;
    do begin
      @(negedge clk);
      taken = in_valid && !in_stall;
      @(posedge clk);
    end while (!taken);
    items_sent++;
  endtask

  // Unused fields carry random values so that every input bit toggles.
  task automatic send_byte(logic [7:0] b);
    send_item(atte_pkg::OP_BYTE, b, 12'($urandom));
  endtask

  task automatic send_read(logic [11:0] idx);
    send_item(atte_pkg::OP_READ, 8'($urandom), idx);
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  task automatic send_csi(string params, logic [7:0] fin);
    if ($urandom_range(0, 1)) send_byte(atte_pkg::CH_CSI);
    else begin
      send_byte(atte_pkg::CH_ESC);
      send_byte(atte_pkg::CH_LBRACKET);
    end
    send_text(params);
    send_byte(fin);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    wait (pending == 0);
    repeat (100) @(posedge clk);
  endtask

  task automatic write_default_fg(logic [3:0] v);
    cfg_we <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  function automatic string rand_number();
    case ($urandom_range(0, 5))
      0: return "";
      1: return $sformatf("%0d", $urandom_range(0, 99999));
      2: return $sformatf("%0d", $urandom_range(30, 47));
      default: return $sformatf("%0d", $urandom_range(0, 40));
    endcase
  endfunction

  task automatic send_random_sequence();
    string p;
    int n;
    logic [7:0] finals [10] = '{atte_pkg::FIN_UP, atte_pkg::FIN_DOWN,
                                atte_pkg::FIN_RIGHT, atte_pkg::FIN_LEFT,
                                atte_pkg::FIN_HOME, atte_pkg::FIN_CLR_LN,
                                atte_pkg::FIN_SC_SUB, atte_pkg::FIN_SC_ADD,
                                atte_pkg::FIN_SGR, 8'h7E};
    n = $urandom_range(0, 3);
    p = "";
    for (int i = 0; i < n; i++) p = (i == 0) ? rand_number() : {p, ";", rand_number()};
    if ($urandom_range(0, 15) == 0) p = {"?", p};
    if ($urandom_range(0, 60) == 0) send_csi(p, atte_pkg::FIN_CLR_SCR);
    else send_csi(p, finals[$urandom_range(0, 9)]);
  endtask

  task automatic send_random_items(int count);
    int start;
    start = items_sent;
    while (items_sent - start < count) begin
      case ($urandom_range(0, 19))
        0, 1, 2, 3, 4, 5: send_byte(8'($urandom_range(32, 126)));
        6: send_byte(8'($urandom));
        7, 8, 9: send_read(($urandom_range(0, 9) == 0) ? 12'($urandom)
                                                     : 12'($urandom_range(0, 2559)));
        10: send_byte(atte_pkg::CH_BS);
        11: send_byte(atte_pkg::CH_CR);
        12: send_byte(atte_pkg::CH_LF);
        13: send_byte(atte_pkg::CH_TAB);
        14: begin
          send_byte(atte_pkg::CH_ESC);
          send_byte(8'($urandom));
        end
        15: begin
          // Overlong sequence: the byte after a full buffer rings the bell.
          send_byte(atte_pkg::CH_CSI);
          for (int i = 0; i < 15; i++) send_byte(8'($urandom_range(48, 59)));
          send_byte(atte_pkg::FIN_SGR);
        end
        default: send_random_sequence();
      endcase
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    write_default_fg(4'd15);

    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(atte_pkg::CH_TAB);
    send_byte(atte_pkg::CH_CR);
    send_byte(atte_pkg::CH_LF);
    send_byte(atte_pkg::CH_BS);
    send_byte(atte_pkg::CH_BS);
    send_text("\033X\033!");
    send_csi("5", atte_pkg::FIN_RIGHT);
    send_csi("2;3", atte_pkg::FIN_HOME);
    send_csi("31;1;42", atte_pkg::FIN_SGR);
    send_csi("1;30;40", atte_pkg::FIN_SGR);
    send_csi("9", atte_pkg::FIN_SGR);
    send_csi("28", atte_pkg::FIN_SGR);
    send_csi("", atte_pkg::FIN_CLR_LN);
    send_csi("1", atte_pkg::FIN_CLR_LN);
    send_csi("2", atte_pkg::FIN_CLR_LN);
    send_csi("3", atte_pkg::FIN_SC_SUB);
    send_csi("", atte_pkg::FIN_SC_ADD);
    send_csi("99999", atte_pkg::FIN_UP);
    send_csi("", atte_pkg::FIN_CLR_SCR);
    send_read(12'd0);
    send_read(12'd2559);
    send_read(12'd4095);

    settle();
    write_default_fg(4'd0);
    send_random_items(400);
    // Sender pauses here until every result has come back.
    settle();
    write_default_fg(4'($urandom));
    send_random_items(350);
    settle();
    write_default_fg(4'd15);
    send_random_items(350);
    settle();

    if (fail_count == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule
